// ----- design/lstpd_pkg.sv -----
`timescale 1ns / 1ps

package lstpd_pkg;

   // Field widths fixed by the item formats.
   localparam int RANGE_W  = 16;
   localparam int ANGLE_W  = 16;
   localparam int STEP_W   = 12;
   localparam int IDX_W    = 12;
   localparam int COORD_W  = 17;
   localparam int POINT_W  = 2 * COORD_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_LOWER = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_UPPER = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_ANGLE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_STEP  = 2'd3;

   // CORDIC datapath sizing.
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = 4;
   localparam int XY_W         = 28;
   localparam int Z_W          = 34;
   localparam int PROD_W       = 59;
   localparam int QUOT_W       = 21;

   // Gain compensation factor in Q30 and the rounding offset for the final shift.
   localparam logic signed [30:0]       INV_GAIN  = 31'sd652032875;
   localparam logic signed [PROD_W-1:0] ROUND_OFS = 59'sd137438953472;
   localparam int                       SCALE_SH  = 38;
   localparam int                       COORD_LIM = 65535;

   // Quarter and half turn in 16-bit binary angle units.
   localparam int QUARTER_TURN = 16384;
   localparam int HALF_TURN    = 32768;

   typedef enum logic [2:0] {
      TS_IDLE,
      TS_CONVERT,
      TS_CHECK,
      TS_READ,
      TS_SHOW
   } top_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_ROTATE,
      CS_MUL_X,
      CS_MUL_Y,
      CS_SAT_Y
   } cordic_state_type;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic signed [Z_W-1:0] atan_lookup(input logic [ITER_W-1:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         4'd0:    v = 34'sd536870912;
         4'd1:    v = 34'sd316933406;
         4'd2:    v = 34'sd167458907;
         4'd3:    v = 34'sd85004756;
         4'd4:    v = 34'sd42667331;
         4'd5:    v = 34'sd21354465;
         4'd6:    v = 34'sd10680862;
         4'd7:    v = 34'sd5340245;
         4'd8:    v = 34'sd2670163;
         4'd9:    v = 34'sd1335087;
         4'd10:   v = 34'sd667544;
         4'd11:   v = 34'sd333772;
         4'd12:   v = 34'sd166886;
         4'd13:   v = 34'sd83443;
         4'd14:   v = 34'sd41722;
         4'd15:   v = 34'sd20861;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/lstpd_point_mem.sv -----
`timescale 1ns / 1ps

module lstpd_point_mem
   import lstpd_pkg::*;
#(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [POINT_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [POINT_W-1:0] rd_data
);

   logic [POINT_W-1:0] mem_ff [DEPTH];
   logic [POINT_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lstpd_cordic.sv -----
`timescale 1ns / 1ps

module lstpd_cordic
   import lstpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [RANGE_W-1:0]        range_mm,
   input  logic [ANGLE_W-1:0]        angle,
   output logic                      done,
   output logic signed [COORD_W-1:0] point_x,
   output logic signed [COORD_W-1:0] point_y
);

   cordic_state_type          state_ff, state_in;
   logic                      done_ff, done_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [XY_W-1:0]    x_ff, x_in;
   logic signed [XY_W-1:0]    y_ff, y_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [COORD_W-1:0] px_ff, px_in;
   logic signed [COORD_W-1:0] py_ff, py_in;

   logic signed [ANGLE_W+1:0] ang_s;
   logic signed [ANGLE_W+1:0] ang_fold;
   logic signed [XY_W-1:0]    x_start;
   logic                      flip;
   logic signed [XY_W-1:0]    dx;
   logic signed [XY_W-1:0]    dy;
   logic signed [Z_W-1:0]     atan_i;

   // Round half up, floor shift and clamp to the coordinate range.
   function automatic logic signed [COORD_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] rnd;
      logic signed [QUOT_W-1:0] q;
      rnd = p + ROUND_OFS;
      q   = $signed(rnd[PROD_W-1:SCALE_SH]);
      if (q > QUOT_W'(COORD_LIM)) begin
         return COORD_W'(COORD_LIM);
      end else if (q < -QUOT_W'(COORD_LIM)) begin
         return -COORD_W'(COORD_LIM);
      end
      return q[COORD_W-1:0];
   endfunction

   // Fold the angle into plus or minus a quarter turn, negating the start vector.
   always_comb begin
      ang_s   = (ANGLE_W+2)'($signed(angle));
      x_start = $signed({{(XY_W-RANGE_W-8){1'b0}}, range_mm, 8'b0});
      if (ang_s > (ANGLE_W+2)'(QUARTER_TURN)) begin
         ang_fold = ang_s - (ANGLE_W+2)'(HALF_TURN);
         flip     = 1'b1;
      end else if (ang_s < -(ANGLE_W+2)'(QUARTER_TURN)) begin
         ang_fold = ang_s + (ANGLE_W+2)'(HALF_TURN);
         flip     = 1'b1;
      end else begin
         ang_fold = ang_s;
         flip     = 1'b0;
      end
   end

   // One rotation step per cycle on the shared shifters.
   always_comb begin
      dx     = y_ff >>> iter_ff;
      dy     = x_ff >>> iter_ff;
      atan_i = atan_lookup(iter_ff);
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      prod_in  = prod_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               x_in     = flip ? -x_start : x_start;
               y_in     = '0;
               z_in     = Z_W'(ang_fold) <<< 16;
               iter_in  = '0;
               state_in = CS_ROTATE;
            end
         end
         CS_ROTATE: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_i;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_i;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = CS_MUL_X;
            end
         end
         CS_MUL_X: begin
            prod_in  = PROD_W'(x_ff * INV_GAIN);
            state_in = CS_MUL_Y;
         end
         CS_MUL_Y: begin
            prod_in  = PROD_W'(y_ff * INV_GAIN);
            px_in    = scale_sat(prod_ff);
            state_in = CS_SAT_Y;
         end
         CS_SAT_Y: begin
            py_in    = scale_sat(prod_ff);
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      prod_ff <= prod_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
   end

   assign done    = done_ff;
   assign point_x = px_ff;
   assign point_y = py_ff;

endmodule

// ----- design/lidar_scan_to_points_decimator_top.sv -----
`timescale 1ns / 1ps
// Channel   Ports                           Contents
// req       req_tvalid/tready/tdata/tlast   range_mm in tdata[15:0], scan_end on tlast
// rsp       rsp_tvalid/tready/tdata/tlast   point_x [16:0], point_y [33:17], final_point on tlast
// csr       csr_we/addr/wdata               write-only register port, no wait
//
// A sample outside the range window is dropped without conversion. A kept sample goes through
// the 16 iterations of the shared CORDIC unit, then gain scaling, and is then stored.
// After the scan end, a check state, then a memory read and an output state per emitted point;
// the output state holds while rsp_tready is low.
// Reset is synchronous and active high; the point memory needs no clearing pass.
// No sample is accepted while a sample is converted or the scan's points are emitted.

module lidar_scan_to_points_decimator_top
   import lstpd_pkg::*;
#(
   parameter int MAX_POINTS    = 2048,
   parameter int TARGET_POINTS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // range_mm [15:0]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // point_x [16:0], point_y [33:17]
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int REM_W  = (TARGET_POINTS > 1) ? $clog2(TARGET_POINTS) : 1;

   top_state_type       state_ff, state_in;
   logic [RANGE_W-1:0]  range_lower_ff;
   logic [RANGE_W-1:0]  range_upper_ff;
   logic [ANGLE_W-1:0]  start_angle_ff;
   logic [STEP_W-1:0]   angle_step_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    quot_ff, quot_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic                last_ff, last_in;

   logic [RANGE_W-1:0]        range_mm;
   logic                      keep;
   logic [IDX_W+STEP_W-1:0]   angle_prod;
   logic [ANGLE_W-1:0]        angle;
   logic                      cordic_start;
   logic                      cordic_done;
   logic signed [COORD_W-1:0] cordic_x;
   logic signed [COORD_W-1:0] cordic_y;
   logic                      mem_we;
   logic                      mem_re;
   logic [POINT_W-1:0]        mem_rdata;
   logic [CNT_W:0]            j_next;
   logic                      final_point;

   assign range_mm   = req_tdata[RANGE_W-1:0];
   assign keep       = (range_mm > range_lower_ff) && (range_mm < range_upper_ff) &&
                       (count_ff != CNT_W'(MAX_POINTS));
   assign angle_prod = (IDX_W+STEP_W)'(idx_ff * angle_step_ff);
   assign angle      = start_angle_ff + angle_prod[ANGLE_W-1:0];

   assign j_next      = {1'b0, j_ff} + {1'b0, step_ff};
   assign final_point = (j_next >= {1'b0, count_ff});

   lstpd_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (cordic_start),
      .range_mm (range_mm),
      .angle    (angle),
      .done     (cordic_done),
      .point_x  (cordic_x),
      .point_y  (cordic_y)
   );

   lstpd_point_mem #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_point_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({cordic_y, cordic_x}),
      .rd_en   (mem_re),
      .rd_addr (j_ff[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   // Sequencer: accept, convert and store, then emit the decimated points.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      j_in         = j_ff;
      last_in      = last_ff;
      cordic_start = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      case (state_ff)
         TS_IDLE: begin
            if (req_tvalid) begin
               idx_in  = idx_ff + 1'b1;
               last_in = req_tlast;
               if (keep) begin
                  cordic_start = 1'b1;
                  state_in     = TS_CONVERT;
               end else if (req_tlast) begin
                  state_in = TS_CHECK;
               end
            end
         end
         TS_CONVERT: begin
            if (cordic_done) begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
               // Running quotient of the stored count by the target point count.
               if (rem_ff == REM_W'(TARGET_POINTS - 1)) begin
                  rem_in  = '0;
                  quot_in = quot_ff + 1'b1;
               end else begin
                  rem_in = rem_ff + 1'b1;
               end
               state_in = last_ff ? TS_CHECK : TS_IDLE;
            end
         end
         TS_CHECK: begin
            if (count_ff == '0) begin
               idx_in   = '0;
               quot_in  = '0;
               rem_in   = '0;
               state_in = TS_IDLE;
            end else begin
               step_in  = (quot_ff == '0) ? CNT_W'(1) : quot_ff;
               j_in     = '0;
               state_in = TS_READ;
            end
         end
         TS_READ: begin
            mem_re   = 1'b1;
            state_in = TS_SHOW;
         end
         TS_SHOW: begin
            if (rsp_tready) begin
               if (final_point) begin
                  idx_in   = '0;
                  count_in = '0;
                  quot_in  = '0;
                  rem_in   = '0;
                  state_in = TS_IDLE;
               end else begin
                  j_in     = j_next[CNT_W-1:0];
                  state_in = TS_READ;
               end
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TS_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         quot_ff  <= '0;
         rem_ff   <= '0;
         step_ff  <= '0;
         j_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         step_ff  <= step_in;
         j_ff     <= j_in;
         last_ff  <= last_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_lower_ff <= 16'd0;
         range_upper_ff <= 16'd65535;
         start_angle_ff <= 16'h8000;
         angle_step_ff  <= 12'd91;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RANGE_LOWER: range_lower_ff <= csr_wdata[RANGE_W-1:0];
            CSR_RANGE_UPPER: range_upper_ff <= csr_wdata[RANGE_W-1:0];
            CSR_START_ANGLE: start_angle_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == TS_IDLE);
   assign rsp_tvalid = (state_ff == TS_SHOW);
   assign rsp_tdata  = {{(40 - POINT_W){1'b0}}, mem_rdata};
   assign rsp_tlast  = final_point;

endmodule
